### rtl/core/lrast_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
package lrast_pkg;

  // Default coordinate width of the endpoints and pixels.
  localparam int COORD_BITS_DEFAULT = 12;

  // Command codes carried on the cmd field.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Line class chosen at setup time and followed on every step.
  typedef enum logic [3:0] {
    CASE_POINT   = 4'd0,
    CASE_HORIZ   = 4'd1,
    CASE_VERT    = 4'd2,
    CASE_DIAG_PP = 4'd3,
    CASE_DIAG_PM = 4'd4,
    CASE_DIAG_MP = 4'd5,
    CASE_DIAG_MM = 4'd6,
    CASE_OCT1    = 4'd7,
    CASE_OCT2    = 4'd8,
    CASE_OCT3    = 4'd9,
    CASE_OCT4    = 4'd10
  } line_case_t;

endpackage

### rtl/core/lrast_setup.sv
// Line classification and Bresenham error term setup for a start beat.
module lrast_setup #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEFAULT
) (
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  output lrast_pkg::line_case_t        init_case,
  output logic [COORD_BITS-1:0]        init_x,
  output logic [COORD_BITS-1:0]        init_y,
  output logic [COORD_BITS+1:0]        init_err,
  output logic [COORD_BITS+1:0]        init_keep,
  output logic [COORD_BITS+1:0]        init_move,
  output logic [COORD_BITS:0]          init_steps
);

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 2;

  logic signed [DW-1:0] ddx, ddy;
  logic [DW-1:0]        adx_w, ady_w;
  logic [CW-1:0]        adx, ady;
  logic                 dx_pos, dy_pos, same_sign, x_lt, y_lt;
  logic [EW-1:0]        two_adx, two_ady;
  logic [CW-1:0]        min_x, min_y, y_at_min_x, x_at_min_y;

  // Signed deltas and their magnitudes; a magnitude always fits the coordinate width.
  assign ddx   = {x2[CW-1], x2} - {x1[CW-1], x1};
  assign ddy   = {y2[CW-1], y2} - {y1[CW-1], y1};
  assign adx_w = ddx[DW-1] ? -ddx : ddx;
  assign ady_w = ddy[DW-1] ? -ddy : ddy;
  assign adx   = adx_w[CW-1:0];
  assign ady   = ady_w[CW-1:0];

  assign dx_pos    = !ddx[DW-1] && (ddx != '0);
  assign dy_pos    = !ddy[DW-1] && (ddy != '0);
  assign same_sign = (dx_pos == dy_pos);
  assign x_lt      = (x1 < x2);
  assign y_lt      = (y1 < y2);

  assign two_adx = {1'b0, adx, 1'b0};
  assign two_ady = {1'b0, ady, 1'b0};

  // Candidate start points.
  assign min_x      = x_lt ? x1 : x2;
  assign y_at_min_x = x_lt ? y1 : y2;
  assign min_y      = y_lt ? y1 : y2;
  assign x_at_min_y = y_lt ? x1 : x2;

  // Classification in priority order, as the pixel order requires.
  always_comb begin
    init_case  = lrast_pkg::CASE_POINT;
    init_x     = x1;
    init_y     = y1;
    init_err   = '0;
    init_keep  = '0;
    init_move  = '0;
    init_steps = '0;
    if (adx == '0 && ady == '0) begin
      init_case = lrast_pkg::CASE_POINT;
    end else if (ady == '0) begin
      init_case  = lrast_pkg::CASE_HORIZ;
      init_x     = min_x;
      init_steps = {1'b0, adx};
    end else if (adx == '0) begin
      init_case  = lrast_pkg::CASE_VERT;
      init_y     = min_y;
      init_steps = {1'b0, ady};
    end else if (adx == ady) begin
      if (dx_pos) begin
        init_case = dy_pos ? lrast_pkg::CASE_DIAG_PP : lrast_pkg::CASE_DIAG_PM;
      end else begin
        init_case = dy_pos ? lrast_pkg::CASE_DIAG_MP : lrast_pkg::CASE_DIAG_MM;
      end
      init_steps = {1'b0, adx};
    end else if (adx > ady) begin
      // Shallow lines run in ascending x.
      init_case  = same_sign ? lrast_pkg::CASE_OCT1 : lrast_pkg::CASE_OCT3;
      init_x     = min_x;
      init_y     = y_at_min_x;
      init_err   = two_ady - {2'b00, adx};
      init_keep  = two_ady;
      init_move  = two_ady - two_adx;
      init_steps = {1'b0, adx};
    end else begin
      // Steep positive lines start at the lower y, steep negative ones at the lower x.
      if (same_sign) begin
        init_case = lrast_pkg::CASE_OCT2;
        init_x    = x_at_min_y;
        init_y    = min_y;
      end else begin
        init_case = lrast_pkg::CASE_OCT4;
        init_x    = min_x;
        init_y    = y_at_min_x;
      end
      init_err   = two_adx - {2'b00, ady};
      init_keep  = two_adx;
      init_move  = two_adx - two_ady;
      init_steps = {1'b0, ady};
    end
  end

endmodule

### rtl/core/lrast_step.sv
// Per-pixel advance: one error add, one sign test and the coordinate moves.
module lrast_step #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEFAULT
) (
  input  lrast_pkg::line_case_t  line_case,
  input  logic [COORD_BITS-1:0]  cur_x,
  input  logic [COORD_BITS-1:0]  cur_y,
  input  logic [COORD_BITS+1:0]  err_acc,
  input  logic [COORD_BITS+1:0]  inc_keep,
  input  logic [COORD_BITS+1:0]  inc_move,
  output logic [COORD_BITS-1:0]  cur_x_next,
  output logic [COORD_BITS-1:0]  cur_y_next,
  output logic [COORD_BITS+1:0]  err_acc_next
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic          minor_move;
  logic [CW-1:0] x_inc, x_dec, y_inc, y_dec;
  logic [EW-1:0] err_sum;

  // A non-negative decision term moves the minor axis.
  assign minor_move = !err_acc[EW-1];
  assign err_sum    = err_acc + (minor_move ? inc_move : inc_keep);

  assign x_inc = cur_x + CW'(1);
  assign x_dec = cur_x - CW'(1);
  assign y_inc = cur_y + CW'(1);
  assign y_dec = cur_y - CW'(1);

  // Coordinate update for each line class.
  always_comb begin
    cur_x_next   = cur_x;
    cur_y_next   = cur_y;
    err_acc_next = err_acc;
    case (line_case)
      lrast_pkg::CASE_HORIZ: cur_x_next = x_inc;
      lrast_pkg::CASE_VERT:  cur_y_next = y_inc;
      lrast_pkg::CASE_DIAG_PP: begin
        cur_x_next = x_inc;
        cur_y_next = y_inc;
      end
      lrast_pkg::CASE_DIAG_PM: begin
        cur_x_next = x_inc;
        cur_y_next = y_dec;
      end
      lrast_pkg::CASE_DIAG_MP: begin
        cur_x_next = x_dec;
        cur_y_next = y_inc;
      end
      lrast_pkg::CASE_DIAG_MM: begin
        cur_x_next = x_dec;
        cur_y_next = y_dec;
      end
      lrast_pkg::CASE_OCT1: begin
        err_acc_next = err_sum;
        cur_x_next   = x_inc;
        cur_y_next   = minor_move ? y_inc : cur_y;
      end
      lrast_pkg::CASE_OCT2: begin
        err_acc_next = err_sum;
        cur_y_next   = y_inc;
        cur_x_next   = minor_move ? x_inc : cur_x;
      end
      lrast_pkg::CASE_OCT3: begin
        err_acc_next = err_sum;
        cur_x_next   = x_inc;
        cur_y_next   = minor_move ? y_dec : cur_y;
      end
      lrast_pkg::CASE_OCT4: begin
        err_acc_next = err_sum;
        cur_y_next   = y_dec;
        cur_x_next   = minor_move ? x_inc : cur_x;
      end
      default: begin
        cur_x_next   = cur_x;
        cur_y_next   = cur_y;
        err_acc_next = err_acc;
      end
    endcase
  end

endmodule

### rtl/core/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: input register, line state, pixel register.
//
// Usage: send a start beat (cmd = 0) with both endpoints and a color, then one step
// beat (cmd = 1) per pixel. A start beat produces no output beat; it classifies the
// line and loads the error terms. Each step beat while a line is active produces one
// output beat with pixel_x, pixel_y, pixel_color and last_pixel; a step beat with no
// active line is consumed and produces nothing. A start beat abandons any open line.
// Both channels use valid and stall; a beat moves at an edge with valid high and
// stall low.
// An accepted beat is held in the input register, then its pixel is registered in the
// pixel register, from which the output beat moves.
// Throughput: one beat per cycle, start or step, while no pixel is held back by a
// stalled receiver, set by the combinational error add and compare that updates the
// line state for the next pixel.
// When the receiver stalls with a pixel waiting, a step beat in the input register
// waits too and in_stall rises; start beats and idle steps still pass through.
// Reset (rst, synchronous) empties both registers and leaves no line active.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [3:0]                   draw_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [3:0]                   pixel_color,
  output logic                         last_pixel
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;
  localparam int SW = COORD_BITS + 1;

  // Input register.
  logic                 hold_valid;
  logic                 hold_cmd;
  logic signed [CW-1:0] hold_sx, hold_sy, hold_ex, hold_ey;
  logic [3:0]           hold_color;

  // Line state.
  lrast_pkg::line_case_t line_case;
  logic [CW-1:0]         cur_x, cur_y;
  logic [EW-1:0]         err_acc, inc_keep, inc_move;
  logic [SW-1:0]         steps_left;
  logic [3:0]            pen_color;
  logic                  line_active;

  // Setup and step results.
  lrast_pkg::line_case_t init_case;
  logic [CW-1:0]         init_x, init_y, cur_x_next, cur_y_next;
  logic [EW-1:0]         init_err, init_keep, init_move, err_acc_next;
  logic [SW-1:0]         init_steps;

  logic emit, advance_ok, fire;

  // A beat leaves the input register unless it would emit into a full, stalled output.
  assign emit       = (hold_cmd == lrast_pkg::CMD_STEP) && line_active;
  assign advance_ok = !emit || !out_valid || !out_stall;
  assign fire       = hold_valid && advance_ok;
  assign in_stall   = hold_valid && !advance_ok;

  lrast_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .x1         (hold_sx),
    .y1         (hold_sy),
    .x2         (hold_ex),
    .y2         (hold_ey),
    .init_case  (init_case),
    .init_x     (init_x),
    .init_y     (init_y),
    .init_err   (init_err),
    .init_keep  (init_keep),
    .init_move  (init_move),
    .init_steps (init_steps)
  );

  lrast_step #(.COORD_BITS(COORD_BITS)) u_step (
    .line_case    (line_case),
    .cur_x        (cur_x),
    .cur_y        (cur_y),
    .err_acc      (err_acc),
    .inc_keep     (inc_keep),
    .inc_move     (inc_move),
    .cur_x_next   (cur_x_next),
    .cur_y_next   (cur_y_next),
    .err_acc_next (err_acc_next)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_cmd   <= cmd;
      hold_sx    <= start_x;
      hold_sy    <= start_y;
      hold_ex    <= end_x;
      hold_ey    <= end_y;
      hold_color <= draw_color;
    end
  end

  // Line active flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire && hold_cmd == lrast_pkg::CMD_START) begin
        line_active <= 1'b1;
      end else if (fire && emit && steps_left == '0) begin
        line_active <= 1'b0;
      end
    end
  end

  // Line state and pixel payload.
  always_ff @(posedge clk) begin
    if (fire && hold_cmd == lrast_pkg::CMD_START) begin
      line_case  <= init_case;
      cur_x      <= init_x;
      cur_y      <= init_y;
      err_acc    <= init_err;
      inc_keep   <= init_keep;
      inc_move   <= init_move;
      steps_left <= init_steps;
      pen_color  <= hold_color;
    end else if (fire && emit) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_color <= pen_color;
      last_pixel  <= (steps_left == '0);
      if (steps_left != '0) begin
        steps_left <= steps_left - SW'(1);
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        err_acc    <= err_acc_next;
      end
    end
  end

  // The input side only waits behind a pixel that the receiver is holding back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && out_valid && out_stall && line_active))
    else $error("input stall without a blocked pixel");

  // A start beat always opens a line.
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_cmd == lrast_pkg::CMD_START) |=> line_active)
    else $error("start beat did not open a line");

  // The final pixel closes the line and is flagged as last.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (fire && emit && steps_left == '0) |=> (!line_active && out_valid && last_pixel))
    else $error("final pixel did not close the line");

endmodule
